/* rtl/vector_stroke_point_generator_assert.svh */
// assertion macros for the stroke point generator
`ifndef VECTOR_STROKE_POINT_GENERATOR_ASSERT_SVH
`define VECTOR_STROKE_POINT_GENERATOR_ASSERT_SVH

// same-cycle implication
`define VSPG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vspg assertion failed");

// next-cycle implication
`define VSPG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vspg assertion failed");

// condition that must never hold
`define VSPG_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("vspg assertion failed");

`endif

/* rtl/vspg_pkg.sv */
package vspg_pkg;

    localparam int COORD_W = 16;
    localparam int T_W     = 17;
    localparam int A_W     = 19;
    localparam int CH_W    = 17;
    localparam int B_W     = 51;
    localparam int ACC_W   = 70;
    localparam int CNT_W   = 6;
    localparam int PIX_W   = 8;
    localparam int STEP_W  = 4;

    localparam logic [2:0] CMD_LINE  = 3'd0;
    localparam logic [2:0] CMD_QUAD  = 3'd1;
    localparam logic [2:0] CMD_CUBIC = 3'd2;
    localparam logic [2:0] CMD_BLANK = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CALC,
        ST_WRAP,
        ST_POINT,
        ST_BLANK
    } state_t;

    // multiplier small operand
    typedef enum logic [3:0] {
        A_MT,
        A_T,
        A_MT3,
        A_T3,
        A_P0,
        A_C1,
        A_C1X2,
        A_C2,
        A_P1
    } asel_t;

    // multiplier wide operand, taken one chunk at a time
    typedef enum logic [3:0] {
        B_MT,
        B_T,
        B_P2,
        B_MTT,
        B_T2,
        B_W0,
        B_W1,
        B_W2,
        B_W3
    } bsel_t;

    typedef enum logic [3:0] {
        D_NONE,
        D_P2,
        D_MTT,
        D_T2,
        D_W0,
        D_W1,
        D_W2,
        D_W3,
        D_X,
        D_Y
    } dest_t;

    typedef struct packed {
        asel_t       asel;
        bsel_t       bsel;
        logic [1:0]  ch_last;
        logic        keep;
        logic        axis_y;
        dest_t       dest;
        logic        last;
    } op_t;

    function automatic op_t mk_op(asel_t a, bsel_t b, logic [1:0] cl, logic kp,
                                  logic ay, dest_t d, logic lst);
        op_t o;
        o.asel    = a;
        o.bsel    = b;
        o.ch_last = cl;
        o.keep    = kp;
        o.axis_y  = ay;
        o.dest    = d;
        o.last    = lst;
        return o;
    endfunction

    // micro program: one product (one or more chunks) per step
    function automatic op_t prog_op(logic [2:0] kind, logic [STEP_W-1:0] step);
        op_t         o;
        logic [STEP_W-1:0] s;
        logic        ay;
        logic [1:0]  k;
        o  = mk_op(A_MT, B_MT, 2'd0, 1'b0, 1'b0, D_NONE, 1'b1);
        s  = '0;
        ay = 1'b0;
        k  = 2'd0;
        case (kind)
            CMD_LINE:
            begin
                ay = step[1];
                k  = {1'b0, step[0]};
                o  = mk_op(k[0] ? A_P1 : A_P0, k[0] ? B_T : B_MT, 2'd0, k[0], ay,
                           k[0] ? (ay ? D_Y : D_X) : D_NONE, ay & k[0]);
            end
            CMD_QUAD:
            begin
                case (step)
                    4'd0: o = mk_op(A_MT, B_MT, 2'd0, 1'b0, 1'b0, D_P2, 1'b0);
                    4'd1: o = mk_op(A_MT, B_T, 2'd0, 1'b0, 1'b0, D_MTT, 1'b0);
                    4'd2: o = mk_op(A_T, B_T, 2'd0, 1'b0, 1'b0, D_T2, 1'b0);
                    default:
                    begin
                        s  = step - 4'd3;
                        ay = (s >= 4'd3);
                        k  = ay ? 2'(s - 4'd3) : s[1:0];
                        case (k)
                            2'd0:    o = mk_op(A_P0, B_P2, 2'd1, 1'b0, ay, D_NONE, 1'b0);
                            2'd1:    o = mk_op(A_C1X2, B_MTT, 2'd1, 1'b1, ay, D_NONE, 1'b0);
                            default: o = mk_op(A_P1, B_T2, 2'd1, 1'b1, ay,
                                               ay ? D_Y : D_X, ay);
                        endcase
                    end
                endcase
            end
            default:
            begin
                case (step)
                    4'd0: o = mk_op(A_MT, B_MT, 2'd0, 1'b0, 1'b0, D_P2, 1'b0);
                    4'd1: o = mk_op(A_MT, B_T, 2'd0, 1'b0, 1'b0, D_MTT, 1'b0);
                    4'd2: o = mk_op(A_T, B_T, 2'd0, 1'b0, 1'b0, D_T2, 1'b0);
                    4'd3: o = mk_op(A_MT, B_P2, 2'd1, 1'b0, 1'b0, D_W0, 1'b0);
                    4'd4: o = mk_op(A_MT3, B_MTT, 2'd1, 1'b0, 1'b0, D_W1, 1'b0);
                    4'd5: o = mk_op(A_T3, B_MTT, 2'd1, 1'b0, 1'b0, D_W2, 1'b0);
                    4'd6: o = mk_op(A_T, B_T2, 2'd1, 1'b0, 1'b0, D_W3, 1'b0);
                    4'd15: o = mk_op(A_MT, B_MT, 2'd0, 1'b0, 1'b0, D_NONE, 1'b1);
                    default:
                    begin
                        s  = step - 4'd7;
                        ay = s[2];
                        k  = s[1:0];
                        case (k)
                            2'd0:    o = mk_op(A_P0, B_W0, 2'd2, 1'b0, ay, D_NONE, 1'b0);
                            2'd1:    o = mk_op(A_C1, B_W1, 2'd2, 1'b1, ay, D_NONE, 1'b0);
                            2'd2:    o = mk_op(A_C2, B_W2, 2'd2, 1'b1, ay, D_NONE, 1'b0);
                            default: o = mk_op(A_P1, B_W3, 2'd2, 1'b1, ay,
                                               ay ? D_Y : D_X, ay);
                        endcase
                    end
                endcase
            end
        endcase
        return o;
    endfunction

endpackage

/* rtl/vector_stroke_point_generator.sv */
// channel   | dir | handshake              | payload
// ----------+-----+------------------------+---------------------------------------
// s_        | in  | s_tvalid / s_tready    | s_tdata coordinates and count, s_tuser cmd
// m_        | out | m_tvalid / m_tready    | m_tdata x_pos, y_pos, m_tuser stored, m_tlast
// apb       | in  | psel / penable / pready| center_x at 0x0, center_y at 0x4
//
// one command at a time: s_tready is high only while idle
// curves: a restoring divide for the t step (skipped for zero count), then per point
//   the multiplier steps of the curve kind, a wrap state and an output state; the
//   single 19x17 multiply-accumulate unit carries every product
// blank commands give one point per cycle while m_tready is high, reset frame and unused codes stay idle
// output stalls hold the sequencer; reset clears control state, centers go to 128
module vector_stroke_point_generator
    import vspg_pkg::*;
#(
    parameter int FRAME_CAPACITY = 1024
)
(
    input  logic          clk,
    input  logic          rst_n,
    // stroke commands
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [135:0]  s_tdata,  // p0x, p0y, c1x, c1y, c2x, c2y, p1x, p1y, count, zero pad
    input  logic [2:0]    s_tuser,  // cmd
    // display points
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata,  // x_pos, y_pos
    output logic          m_tuser,  // stored
    output logic          m_tlast,  // last point of the command
    // register port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    `include "vector_stroke_point_generator_assert.svh"

    localparam int HELD_W = $clog2(FRAME_CAPACITY);
    localparam logic [HELD_W-1:0] HELD_MAX = HELD_W'(FRAME_CAPACITY - 1);
    localparam logic [T_W-1:0]    T_ONE    = T_W'(65536);
    localparam logic signed [ACC_W-1:0] HALF_L = ACC_W'(1) <<< 19;
    localparam logic signed [ACC_W-1:0] HALF_Q = ACC_W'(1) <<< 35;
    localparam logic signed [ACC_W-1:0] HALF_C = ACC_W'(1) <<< 51;
    localparam logic signed [ACC_W-1:0] PIX_MAX = ACC_W'(255);

    state_t state_reg, state_next;

    // command registers
    logic [2:0]          cmd_reg, cmd_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [COORD_W-1:0]  p0x_reg, p0y_reg, c1x_reg, c1y_reg;
    logic [COORD_W-1:0]  c2x_reg, c2y_reg, p1x_reg, p1y_reg;

    // t walk: t = q*i + floor(r*i/count) kept as quotient and remainder
    logic [T_W-1:0]      t_reg, t_next;
    logic [T_W-1:0]      q_reg, q_next;
    logic [CNT_W-1:0]    r_reg, r_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [4:0]          dcnt_reg, dcnt_next;

    // sequencer
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [1:0]          ch_reg, ch_next;
    dest_t               pend_reg, pend_next;

    // products kept between steps
    logic [B_W-1:0]      p2_reg, mtt_reg, t2_reg;
    logic [B_W-1:0]      w0_reg, w1_reg, w2_reg, w3_reg;
    logic [PIX_W-1:0]    x_reg, y_reg;

    logic [PIX_W-1:0]    center_x_reg, center_y_reg;
    logic [HELD_W-1:0]   held_reg;

    op_t                 op;
    logic [T_W-1:0]      mt;
    logic signed [A_W-1:0] a_val;
    logic [B_W-1:0]      b_src;
    logic [CH_W-1:0]     b_chunk;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] rnd;
    logic [PIX_W-1:0]    pix;
    logic                s_xfer, m_xfer, stored, run_last;
    logic [CNT_W:0]      div_try, rem_sum;
    logic [COORD_W-1:0]  coord_a;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;
    assign stored = (held_reg != HELD_MAX);
    assign mt     = T_ONE - t_reg;
    assign op     = prog_op(cmd_reg, step_reg);

    // last point of the run: curves end at i == count, blanks at i == count-1
    assign run_last = (state_reg == ST_BLANK)
                    ? (({1'b0, idx_reg} + 7'd1) == {1'b0, count_reg})
                    : (idx_reg == count_reg);

    // ---------------- multiplier operands ----------------
    always_comb
    begin
        case (op.asel)
            A_P0:    coord_a = op.axis_y ? p0y_reg : p0x_reg;
            A_C1:    coord_a = op.axis_y ? c1y_reg : c1x_reg;
            A_C1X2:  coord_a = op.axis_y ? c1y_reg : c1x_reg;
            A_C2:    coord_a = op.axis_y ? c2y_reg : c2x_reg;
            default: coord_a = op.axis_y ? p1y_reg : p1x_reg;
        endcase
        case (op.asel)
            A_MT:    a_val = A_W'(mt);
            A_T:     a_val = A_W'(t_reg);
            A_MT3:   a_val = A_W'({1'b0, mt, 1'b0}) + A_W'(mt);
            A_T3:    a_val = A_W'({1'b0, t_reg, 1'b0}) + A_W'(t_reg);
            A_C1X2:  a_val = {{(A_W-COORD_W-1){coord_a[COORD_W-1]}}, coord_a, 1'b0};
            default: a_val = {{(A_W-COORD_W){coord_a[COORD_W-1]}}, coord_a};
        endcase
        case (op.bsel)
            B_MT:    b_src = B_W'(mt);
            B_T:     b_src = B_W'(t_reg);
            B_P2:    b_src = p2_reg;
            B_MTT:   b_src = mtt_reg;
            B_T2:    b_src = t2_reg;
            B_W0:    b_src = w0_reg;
            B_W1:    b_src = w1_reg;
            B_W2:    b_src = w2_reg;
            default: b_src = w3_reg;
        endcase
        case (ch_reg)
            2'd0:    b_chunk = b_src[CH_W-1:0];
            2'd1:    b_chunk = b_src[2*CH_W-1:CH_W];
            default: b_chunk = b_src[3*CH_W-1:2*CH_W];
        endcase
    end

    vspg_mac u_mac (
        .clk   (clk),
        .en    (state_reg == ST_CALC),
        .clear ((ch_reg == 2'd0) && !op.keep),
        .a     (a_val),
        .b     (b_chunk),
        .sh    (ch_reg),
        .acc   (acc)
    );

    // round half up at the fraction width of the curve kind, then clamp
    always_comb
    begin
        case (cmd_reg)
            CMD_LINE: rnd = (acc + HALF_L) >>> 20;
            CMD_QUAD: rnd = (acc + HALF_Q) >>> 36;
            default:  rnd = (acc + HALF_C) >>> 52;
        endcase
        if (rnd < 0)
        begin
            pix = '0;
        end
        else if (rnd > PIX_MAX)
        begin
            pix = '1;
        end
        else
        begin
            pix = rnd[PIX_W-1:0];
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    if (s_tuser == CMD_LINE || s_tuser == CMD_QUAD || s_tuser == CMD_CUBIC)
                    begin
                        state_next = (s_tdata[133:128] == '0) ? ST_CALC : ST_DIV;
                    end
                    else if (s_tuser == CMD_BLANK && s_tdata[133:128] != '0)
                    begin
                        state_next = ST_BLANK;
                    end
                end
            end
            ST_DIV:
            begin
                if (dcnt_reg == 5'd16)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (ch_reg == op.ch_last && op.last)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                state_next = ST_POINT;
            end
            ST_POINT:
            begin
                if (m_xfer)
                begin
                    state_next = run_last ? ST_IDLE : ST_CALC;
                end
            end
            ST_BLANK:
            begin
                if (m_xfer && run_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath next values ----------------
    always_comb
    begin
        cmd_next   = cmd_reg;
        count_next = count_reg;
        t_next     = t_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        dcnt_next  = dcnt_reg;
        step_next  = step_reg;
        ch_next    = ch_reg;
        pend_next  = D_NONE;
        div_try    = {r_reg, (dcnt_reg == 5'd0)};
        rem_sum    = {1'b0, rem_reg} + {1'b0, r_reg};
        case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    cmd_next   = s_tuser;
                    count_next = s_tdata[133:128];
                    t_next     = '0;
                    q_next     = '0;
                    r_next     = '0;
                    rem_next   = '0;
                    idx_next   = '0;
                    dcnt_next  = '0;
                    step_next  = '0;
                    ch_next    = '0;
                end
            end
            ST_DIV:
            begin
                // restoring division of 65536 by count, one quotient bit a cycle
                if (div_try >= {1'b0, count_reg})
                begin
                    r_next = CNT_W'(div_try - {1'b0, count_reg});
                    q_next = {q_reg[T_W-2:0], 1'b1};
                end
                else
                begin
                    r_next = div_try[CNT_W-1:0];
                    q_next = {q_reg[T_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 5'd1;
            end
            ST_CALC:
            begin
                if (ch_reg == op.ch_last)
                begin
                    ch_next   = '0;
                    pend_next = op.dest;
                    if (!op.last)
                    begin
                        step_next = step_reg + 4'd1;
                    end
                end
                else
                begin
                    ch_next = ch_reg + 2'd1;
                end
            end
            ST_POINT:
            begin
                if (m_xfer && !run_last)
                begin
                    idx_next  = idx_reg + 6'd1;
                    step_next = '0;
                    ch_next   = '0;
                    if (rem_sum >= {1'b0, count_reg})
                    begin
                        rem_next = CNT_W'(rem_sum - {1'b0, count_reg});
                        t_next   = t_reg + q_reg + 17'd1;
                    end
                    else
                    begin
                        rem_next = rem_sum[CNT_W-1:0];
                        t_next   = t_reg + q_reg;
                    end
                end
            end
            ST_BLANK:
            begin
                if (m_xfer)
                begin
                    idx_next = idx_reg + 6'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pend_reg     <= D_NONE;
            step_reg     <= '0;
            ch_reg       <= '0;
            dcnt_reg     <= '0;
            idx_reg      <= '0;
            held_reg     <= '0;
            center_x_reg <= 8'd128;
            center_y_reg <= 8'd128;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            step_reg  <= step_next;
            ch_reg    <= ch_next;
            dcnt_reg  <= dcnt_next;
            idx_reg   <= idx_next;
            if (s_xfer && s_tuser == CMD_CLEAR)
            begin
                held_reg <= '0;
            end
            else if (m_xfer && stored)
            begin
                held_reg <= held_reg + 1'b1;
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2])
                begin
                    center_y_reg <= pwdata[PIX_W-1:0];
                end
                else
                begin
                    center_x_reg <= pwdata[PIX_W-1:0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        count_reg <= count_next;
        t_reg     <= t_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        rem_reg   <= rem_next;
        if (s_xfer)
        begin
            p0x_reg <= s_tdata[15:0];
            p0y_reg <= s_tdata[31:16];
            c1x_reg <= s_tdata[47:32];
            c1y_reg <= s_tdata[63:48];
            c2x_reg <= s_tdata[79:64];
            c2y_reg <= s_tdata[95:80];
            p1x_reg <= s_tdata[111:96];
            p1y_reg <= s_tdata[127:112];
        end
        // a finished product lands once its last chunk is in the accumulator, steered by the registered pend_reg
        case (pend_reg)
            D_P2:    p2_reg  <= acc[B_W-1:0];
            D_MTT:   mtt_reg <= acc[B_W-1:0];
            D_T2:    t2_reg  <= acc[B_W-1:0];
            D_W0:    w0_reg  <= acc[B_W-1:0];
            D_W1:    w1_reg  <= acc[B_W-1:0];
            D_W2:    w2_reg  <= acc[B_W-1:0];
            D_W3:    w3_reg  <= acc[B_W-1:0];
            D_X:     x_reg   <= pix;
            D_Y:     y_reg   <= pix;
            default:
            begin
            end
        endcase
    end

    // ---------------- ports ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_POINT) || (state_reg == ST_BLANK);
    assign m_tdata  = (state_reg == ST_BLANK) ? {center_y_reg, center_x_reg}
                                              : {y_reg, x_reg};
    assign m_tuser  = stored;
    assign m_tlast  = run_last;
    assign pready   = 1'b1;
    assign prdata   = {24'd0, paddr[2] ? center_y_reg : center_x_reg};

    // ---------------- checks ----------------
    `VSPG_ASSERT_NEVER(a_no_overlap, s_tready && m_tvalid)
    `VSPG_ASSERT_NEVER(a_held_bound, held_reg > HELD_MAX)
    `VSPG_ASSERT_IMP(a_rem_below, (state_reg == ST_CALC) && (count_reg != '0), rem_reg < count_reg)
    `VSPG_ASSERT_NXT(a_last_idle, m_tvalid && m_tready && m_tlast, s_tready)

endmodule

/* rtl/vspg_mac.sv */
module vspg_mac
    import vspg_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic                    clear,
    input  logic signed [A_W-1:0]   a,
    input  logic [CH_W-1:0]         b,
    input  logic [1:0]              sh,
    output logic signed [ACC_W-1:0] acc
);

    localparam int P_W = A_W + CH_W + 1;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [P_W-1:0]   prod;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] term;

    // signed small operand times one unsigned chunk of the wide operand
    assign prod     = a * $signed({1'b0, b});
    assign prod_ext = {{(ACC_W-P_W){prod[P_W-1]}}, prod};

    always_comb
    begin
        case (sh)
            2'd0:    term = prod_ext;
            2'd1:    term = prod_ext <<< CH_W;
            default: term = prod_ext <<< (2 * CH_W);
        endcase
        acc_next = (clear ? ACC_W'(0) : acc_reg) + term;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* dv/vector_stroke_point_generator_tb.sv */
module vector_stroke_point_generator_tb
    import vspg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // unused command codes, the block must swallow them silently
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    // register byte addresses
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd4;

    localparam int FRAME_CAP   = 1024;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int DRAIN_WAIT  = 60;

    // coordinate slots in transfer order
    localparam int P0X = 0, P0Y = 1, C1X = 2, C1Y = 3, C2X = 4, C2Y = 5, P1X = 6, P1Y = 7;

    typedef logic signed [15:0] coord_t;

    typedef struct packed {
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic       stored;
        logic       last_point;
    } point_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;   // p0x, p0y, c1x, c1y, c2x, c2y, p1x, p1y, count, zero pad
    logic [2:0]   s_tuser;   // cmd
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;   // x_pos, y_pos
    logic         m_tuser;   // stored
    logic         m_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    vector_stroke_point_generator #(.FRAME_CAPACITY(FRAME_CAP)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    // predictor state: mirror of the frame counter and the blank position
    int unsigned frame_points;
    logic [7:0]  blank_x;
    logic [7:0]  blank_y;

    point_t      pending_points[$];
    int          mismatches;
    int          cmds_sent;
    int          points_seen;
    int          dropped_seen;
    int unsigned cycle_count;

    // traffic shaping knobs
    bit          steady;        // no idling on either side
    int          hold_request;  // cycles the receiver must hold off

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // round half up from frac fraction bits, then clamp to a pixel
    function automatic logic [7:0] to_pixel(longint s, int frac);
        longint q;
        longint r;
        q = s >>> (frac - 1);
        r = (q + 1) >>> 1;
        if (r < 0)
            return 8'd0;
        if (r > 255)
            return 8'd255;
        return r[7:0];
    endfunction

    // one axis of a line, quadratic or cubic in Bernstein form, t in Q1.16
    function automatic logic [7:0] curve_axis(logic [2:0] kind, longint t, longint a,
                                              longint b, longint c, longint d);
        longint mt;
        longint s;
        mt = 65536 - t;
        if (kind == CMD_LINE)
            return to_pixel(mt * a + t * d, 20);
        if (kind == CMD_QUAD)
            return to_pixel(mt * mt * a + 2 * mt * t * b + t * t * d, 36);
        s = mt * mt * mt * a;
        s += 3 * mt * mt * t * b;
        s += 3 * mt * t * t * c;
        s += t * t * t * d;
        return to_pixel(s, 52);
    endfunction

    function automatic void push_point(logic [7:0] x, logic [7:0] y, logic lst);
        point_t p;
        p.x_pos      = x;
        p.y_pos      = y;
        p.last_point = lst;
        p.stored     = (frame_points + 1 < FRAME_CAP);
        if (p.stored)
            frame_points++;
        pending_points.push_back(p);
    endfunction

    // expected points for one accepted command
    function automatic void predict_stroke(logic [2:0] cmd, coord_t pt[8], logic [5:0] count);
        longint t;
        if (cmd == CMD_LINE || cmd == CMD_QUAD || cmd == CMD_CUBIC)
        begin
            for (int i = 0; i <= count; i++)
            begin
                t = (count == 0) ? 0 : (longint'(i) << 16) / count;
                push_point(curve_axis(cmd, t, pt[P0X], pt[C1X], pt[C2X], pt[P1X]),
                           curve_axis(cmd, t, pt[P0Y], pt[C1Y], pt[C2Y], pt[P1Y]),
                           i == count);
            end
        end
        else if (cmd == CMD_BLANK)
        begin
            for (int i = 0; i < count; i++)
                push_point(blank_x, blank_y, i + 1 == count);
        end
        else if (cmd == CMD_CLEAR)
            frame_points = 0;
    endfunction

    // one stroke command transfer; s_tvalid stays high if the next one follows at once
    task automatic send_stroke(logic [2:0] cmd, coord_t pt[8], logic [5:0] count);
        if (!steady && $urandom_range(99) < 20)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, count, pt[P1Y], pt[P1X], pt[C2Y], pt[C2X],
                     pt[C1Y], pt[C1X], pt[P0Y], pt[P0X]};
        do
            @(posedge clk);
        while (!s_tready);
        predict_stroke(cmd, pt, count);
        cmds_sent++;
    endtask

    task automatic send_idle();
        s_tvalid <= 1'b0;
    endtask

    function automatic coord_t rand_coord();
        // mostly on screen, sometimes anywhere in the full range
        if ($urandom_range(99) < 60)
            return coord_t'($urandom_range(4300) - 200);
        return coord_t'($urandom);
    endfunction

    function automatic logic [5:0] rand_count();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 6'd63;
        if (r < 10)
            return 6'd0;
        if (r < 80)
            return 6'($urandom_range(1, 8));
        return 6'($urandom_range(63));
    endfunction

    task automatic send_random_stroke();
        coord_t     pt[8];
        logic [2:0] cmd;
        int         r;
        foreach (pt[k])
            pt[k] = rand_coord();
        r = $urandom_range(99);
        if (r < 30)
            cmd = CMD_LINE;
        else if (r < 55)
            cmd = CMD_QUAD;
        else if (r < 75)
            cmd = CMD_CUBIC;
        else if (r < 88)
            cmd = CMD_BLANK;
        else if (r < 94)
            cmd = CMD_CLEAR;
        else
            cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        send_stroke(cmd, pt, rand_count());
    endtask

    // wait until every expected point has come out and the block has settled
    task automatic drain();
        send_idle();
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // register write: setup cycle then access cycle, then read the value back
    task automatic write_reg(logic [2:0] addr, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_CENTER_X)
            blank_x = value;
        else
            blank_y = value;
        @(posedge clk);
        if (prdata !== {24'd0, value})
        begin
            $error("center register expected %0d actual %0d", value, prdata);
            mismatches++;
        end
    endtask

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            m_tready     <= 1'b0;
            hold_request <= hold_request - 1;
        end
        else
            m_tready <= steady || ($urandom_range(99) >= 20);
    end

    // point checker
    always @(posedge clk)
    begin
        point_t exp_pt;
        if (rst_n && m_tvalid && m_tready)
        begin
            points_seen++;
            if (!m_tuser)
                dropped_seen++;
            if (pending_points.size() == 0)
            begin
                $error("unexpected point x=%0d y=%0d", m_tdata[7:0], m_tdata[15:8]);
                mismatches++;
            end
            else
            begin
                exp_pt = pending_points.pop_front();
                if (m_tdata[7:0] !== exp_pt.x_pos)
                begin
                    $error("x_pos expected %0d actual %0d", exp_pt.x_pos, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tdata[15:8] !== exp_pt.y_pos)
                begin
                    $error("y_pos expected %0d actual %0d", exp_pt.y_pos, m_tdata[15:8]);
                    mismatches++;
                end
                if (m_tuser !== exp_pt.stored)
                begin
                    $error("stored expected %0d actual %0d", exp_pt.stored, m_tuser);
                    mismatches++;
                end
                if (m_tlast !== exp_pt.last_point)
                begin
                    $error("last_point expected %0d actual %0d", exp_pt.last_point, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[vector_stroke_point_generator] ERROR");
            $finish;
        end
    end

    // every command, extremes of the coordinates, zero counts, ignored codes
    task automatic test_directed();
        coord_t pt[8];
        foreach (pt[k])
            pt[k] = 16'sh7fff;
        send_stroke(CMD_LINE, pt, 6'd3);
        foreach (pt[k])
            pt[k] = 16'sh8000;
        send_stroke(CMD_CUBIC, pt, 6'd2);
        pt = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
               16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
        send_stroke(CMD_LINE, pt, 6'd63);
        send_stroke(CMD_QUAD, pt, 6'd5);
        send_stroke(CMD_CUBIC, pt, 6'd63);
        // on-screen shapes, including half-pixel rounding points
        pt = '{16'sd8, 16'sd24, 16'sd2000, 16'sd4088, 16'sd4095, 16'sd0, 16'sd4080, 16'sd40};
        send_stroke(CMD_LINE, pt, 6'd7);
        send_stroke(CMD_QUAD, pt, 6'd9);
        send_stroke(CMD_CUBIC, pt, 6'd11);
        // zero count: curves give one point at the start, blank gives none
        send_stroke(CMD_LINE, pt, 6'd0);
        send_stroke(CMD_QUAD, pt, 6'd0);
        send_stroke(CMD_CUBIC, pt, 6'd0);
        send_stroke(CMD_BLANK, pt, 6'd0);
        send_stroke(CMD_BLANK, pt, 6'd1);
        send_stroke(CMD_BLANK, pt, 6'd63);
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
            send_stroke(3'(c), pt, 6'd5);
        send_stroke(CMD_CLEAR, pt, 6'd9);
        send_stroke(CMD_LINE, pt, 6'd1);
        drain();
    endtask

    // run the frame past its capacity, then clear it
    task automatic test_frame_full();
        coord_t pt[8];
        foreach (pt[k])
            pt[k] = rand_coord();
        send_stroke(CMD_CLEAR, pt, 6'd0);
        for (int i = 0; i < 17; i++)
            send_stroke(CMD_BLANK, pt, 6'd63);
        send_stroke(CMD_LINE, pt, 6'd4);
        send_stroke(CMD_CUBIC, pt, 6'd3);
        send_stroke(CMD_CLEAR, pt, 6'd0);
        send_stroke(CMD_QUAD, pt, 6'd4);
        drain();
    endtask

    // blank position at its extremes and a random setting
    task automatic test_center_regs();
        coord_t pt[8];
        logic [7:0] vals[3];
        foreach (pt[k])
            pt[k] = '0;
        vals = '{8'd0, 8'd255, 8'($urandom)};
        foreach (vals[v])
        begin
            write_reg(REG_CENTER_X, vals[v]);
            write_reg(REG_CENTER_Y, ~vals[v]);
            send_stroke(CMD_BLANK, pt, 6'd3);
            send_stroke(CMD_LINE, pt, 6'd1);
            drain();
        end
    endtask

    // receiver stops for a long stretch while commands keep coming
    task automatic test_backpressure();
        hold_request = 400;
        for (int i = 0; i < 6; i++)
            send_random_stroke();
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            // a stretch with no idling in the middle
            steady = (i >= n / 3) && (i < n / 3 + 60);
            send_random_stroke();
            // occasionally move the blank position while idle
            if ($urandom_range(99) < 3)
            begin
                drain();
                write_reg(REG_CENTER_X, 8'($urandom));
                write_reg(REG_CENTER_Y, 8'($urandom));
            end
        end
        steady = 1'b0;
        drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_LINE;
        m_tready     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = REG_CENTER_X;
        pwdata       = '0;
        frame_points = 0;
        blank_x      = 8'd128;
        blank_y      = 8'd128;
        mismatches   = 0;
        cmds_sent    = 0;
        points_seen  = 0;
        dropped_seen = 0;
        cycle_count  = 0;
        steady       = 1'b0;
        hold_request = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_frame_full();
        test_center_regs();
        test_backpressure();
        test_random(370);

        $display("covered %0d commands, %0d points checked, %0d of them past a full frame",
                 cmds_sent, points_seen, dropped_seen);
        $display("all command kinds, frame overflow, center registers and output stalls");
        if (mismatches == 0)
            $display("[vector_stroke_point_generator] OK");
        else
            $display("[vector_stroke_point_generator] ERROR");
        $finish;
    end

endmodule
